### design/tca_pkg.sv
// Shared types and constants for the tracklet cluster association block.
// Depends on nothing; every other design file but the checker imports it.
package tca_pkg;

   localparam logic [2:0] OP_SCALE_X    = 3'd0;
   localparam logic [2:0] OP_SCALE_Y    = 3'd1;
   localparam logic [2:0] OP_CLUSTER    = 3'd2;
   localparam logic [2:0] OP_PLANE_DONE = 3'd3;
   localparam logic [2:0] OP_EVENT_DONE = 3'd4;

   localparam logic [1:0] REG_RADIUS_SQ    = 2'd0;
   localparam logic [1:0] REG_MIN_CLUSTERS = 2'd1;
   localparam logic [1:0] REG_NUM_PLANES   = 2'd2;

   localparam int          LEAST_LEN  = 3;
   localparam int          RESULT_CAP = 64;
   localparam int          MEMBER_W   = 11;
   localparam int          RADIUS_W   = 48;

   typedef struct packed {
      logic valid;
      logic hit;
   } match_flag_type;

endpackage

### design/tracklet_cluster_association.sv
// Tracklet cluster association: nearest-neighbour track finding over planes.
// Top level with the sequencer and candidate records; uses tca_pkg and the
// scale table, member store and match pipeline modules.
//
// Clusters arrive plane by plane on the req_ channel and are compared with
// every live track candidate in table order through a four-stage distance
// pipeline fed from the scale tables (one candidate issued per cycle). A
// cluster with one match extends that candidate, with two or more matches
// erases all matched candidates, and with none seeds a candidate if enough
// planes remain. Plane done drops candidates that can no longer reach the
// minimum length; event done streams every member of every survivor on the
// rsp_ channel and clears the table. Items are handled one at a time, with
// req_stall raised until an item is finished: a cluster is compared with
// every live candidate before the decision, an erase or plane done walks
// the candidates once more, and event done sums the track lengths, then for
// each emitted cluster reads the member store, loads the output register and
// waits for the output transfer, which rsp_stall can hold.
// Register writes are taken only while the block is idle. No clearing pass
// is needed after reset.
module tracklet_cluster_association #(
   parameter int MAX_PLANES     = 8,
   parameter int MAX_CANDIDATES = 8,
   parameter int MAX_TRACK_LEN  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_operation,
   input  logic [2:0]                   req_plane,
   input  logic [2:0]                   req_from_plane,
   input  logic [15:0]                  req_inv_scale,
   input  logic [7:0]                   req_cluster_id,
   input  logic signed [15:0]           req_pos_x,
   input  logic signed [15:0]           req_pos_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_entry_valid,
   output logic [2:0]                   rsp_track_index,
   output logic [7:0]                   rsp_out_cluster_id,
   output logic [2:0]                   rsp_out_plane,
   output logic                         rsp_last_of_track,
   output logic                         rsp_last_of_event,
   output logic                         rsp_overflow,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [tca_pkg::RADIUS_W-1:0] csr_data
);
   import tca_pkg::*;

   localparam int MC   = MAX_CANDIDATES;
   localparam int MTL  = MAX_TRACK_LEN;
   localparam int MP   = MAX_PLANES;
   localparam int CIW  = (MC > 1) ? $clog2(MC) : 1;
   localparam int NW   = $clog2(MC + 1);
   localparam int LW   = $clog2(MTL + 1);
   localparam int JW   = $clog2(MTL);
   localparam int SAW  = $clog2(MP * MP);
   localparam int MAW  = (MC * MTL > 1) ? $clog2(MC * MTL) : 1;
   localparam int TW   = $clog2(MC * MTL + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_CMP, S_DECIDE, S_SWEEP, S_SUM, S_ERD, S_EWT, S_EOUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [RADIUS_W-1:0] radius_ff;
   logic [3:0]          minc_ff;
   logic [3:0]          npl_ff;
   logic [4:0]          np;
   logic [3:0]          minlen;

   // held item
   logic [2:0]  p_ff;
   logic [7:0]  id_ff;
   logic [15:0] px_ff, py_ff;

   // candidate records, by physical slot, and the live order list
   logic [2:0]     lastp_ff [MC];
   logic [LW-1:0]  len_ff   [MC];
   logic [15:0]    lx_ff    [MC];
   logic [15:0]    ly_ff    [MC];
   logic [CIW-1:0] ord_ff   [MC];
   logic [MC-1:0]  used_ff;
   logic [NW-1:0]  n_ff;
   logic           ovf_ff;

   // sequencer
   logic [NW-1:0]  k_ff;
   logic [MC-1:0]  hitv_ff;
   logic [1:0]     hits_ff;
   logic [CIW-1:0] first_ff;
   logic           erase_ff;
   logic [TW-1:0]  acc_ff;
   logic [6:0]     total_ff;
   logic [6:0]     ek_ff;
   logic [JW-1:0]  cj_ff;

   // output register
   logic       rsp_valid_ff;
   logic       rsp_entry_ff;
   logic [2:0] rsp_track_ff;
   logic [7:0] rsp_id_ff;
   logic [2:0] rsp_plane_ff;
   logic       rsp_lot_ff;
   logic       rsp_loe_ff;
   logic       rsp_ovf_ff;

   logic                accept;
   logic [CIW-1:0]      rd_k;
   logic [CIW-1:0]      rec_slot;
   logic [2:0]          rec_lastp;
   logic [LW-1:0]       rec_len;
   logic [CIW-1:0]      free_slot;
   logic                sc_wr;
   logic [SAW-1:0]      sc_wr_addr;
   logic [SAW-1:0]      sc_rd_addr;
   logic [15:0]         sc_x, sc_y;
   logic                iss_valid;
   logic signed [16:0]  dx, dy;
   logic [15:0]         ax, ay;
   match_flag_type      mres;
   logic [CIW-1:0]      mres_idx;
   logic                mm_wr;
   logic [MAW-1:0]      mm_wr_addr;
   logic [MAW-1:0]      mm_rd_addr;
   logic [MEMBER_W-1:0] mm_rd_data;
   logic [4:0]          remain;
   logic                drop_now;
   logic                seed_ok;

   assign np = (npl_ff == 4'd0) ? 5'd1 :
               ((5'(npl_ff) > 5'(MP)) ? 5'(MP) : 5'(npl_ff));
   assign minlen = (int'(minc_ff) < LEAST_LEN) ? 4'(LEAST_LEN) : minc_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   // take register writes only between items
   assign csr_ready = (state_ff == S_IDLE);

   // single record read port: the decision reads the first match, all else k
   assign rd_k      = (state_ff == S_DECIDE) ? first_ff : k_ff[CIW-1:0];
   assign rec_slot  = ord_ff[rd_k];
   assign rec_lastp = lastp_ff[rec_slot];
   assign rec_len   = len_ff[rec_slot];

   always_comb begin
      free_slot = '0;
      for (int i = MC - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_slot = CIW'(i);
         end
      end
   end

   // scale table load happens straight on the transfer
   assign sc_wr = accept && (req_operation == OP_SCALE_X || req_operation == OP_SCALE_Y)
                  && int'(req_plane) < MP && int'(req_from_plane) < MP;
   assign sc_wr_addr = SAW'(int'(req_from_plane) * MP + int'(req_plane));
   assign sc_rd_addr = SAW'(int'(rec_lastp) * MP + int'(p_ff));

   tca_scale_mem #(.MAX_PLANES(MP), .AW(SAW)) u_scale (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (sc_wr),
      .wr_y    (req_operation == OP_SCALE_Y),
      .wr_addr (sc_wr_addr),
      .wr_data (req_inv_scale),
      .rd_addr (sc_rd_addr),
      .rd_x    (sc_x),
      .rd_y    (sc_y)
   );

   // position step against the candidate being issued
   assign iss_valid = (state_ff == S_CMP) && (k_ff < n_ff);
   assign dx = $signed({px_ff[15], px_ff}) - $signed({lx_ff[rec_slot][15], lx_ff[rec_slot]});
   assign dy = $signed({py_ff[15], py_ff}) - $signed({ly_ff[rec_slot][15], ly_ff[rec_slot]});
   assign ax = dx[16] ? 16'(-dx) : dx[15:0];
   assign ay = dy[16] ? 16'(-dy) : dy[15:0];

   tca_match #(.CIW(CIW)) u_match (
      .clock     (clock),
      .reset     (reset),
      .iss_valid (iss_valid),
      .iss_idx   (k_ff[CIW-1:0]),
      .iss_ax    (ax),
      .iss_ay    (ay),
      .scale_x   (sc_x),
      .scale_y   (sc_y),
      .radius_sq (radius_ff),
      .res       (mres),
      .res_idx   (mres_idx)
   );

   // member store: extend writes at the current length, a seed at zero
   assign seed_ok = (np - 5'(p_ff)) >= 5'(minlen);
   always_comb begin
      mm_wr      = 1'b0;
      mm_wr_addr = MAW'(int'(rec_slot) * MTL + int'(rec_len));
      if (state_ff == S_DECIDE) begin
         if (hits_ff == 2'd1) begin
            mm_wr = (int'(rec_len) < MTL);
         end else if (hits_ff == 2'd0) begin
            mm_wr      = seed_ok && (int'(n_ff) < MC);
            mm_wr_addr = MAW'(int'(free_slot) * MTL);
         end
      end
   end
   assign mm_rd_addr = MAW'(int'(rec_slot) * MTL + int'(cj_ff));

   tca_member_mem #(.DEPTH(MC * MTL), .AW(MAW)) u_members (
      .clock   (clock),
      .wr_en   (mm_wr),
      .wr_addr (mm_wr_addr),
      .wr_data ({p_ff, id_ff}),
      .rd_addr (mm_rd_addr),
      .rd_data (mm_rd_data)
   );

   // plane done keeps a candidate only if it can still reach the minimum
   assign remain   = ((5'(p_ff) + 5'd1) <= np) ? (np - 5'(p_ff) - 5'd1) : 5'd0;
   assign drop_now = erase_ff ? hitv_ff[k_ff[CIW-1:0]]
                              : ((7'(rec_len) + 7'(remain)) < 7'(minlen));

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         minc_ff   <= 4'd3;
         npl_ff    <= 4'd8;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RADIUS_SQ:    radius_ff <= csr_data;
            REG_MIN_CLUSTERS: minc_ff   <= csr_data[3:0];
            REG_NUM_PLANES:   npl_ff    <= csr_data[3:0];
            default:          ;
         endcase
      end
   end

   // held item and record payload: no reset, records written on every seed and extend
   always_ff @(posedge clock) begin
      if (accept) begin
         p_ff  <= req_plane;
         id_ff <= req_cluster_id;
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
      end
      if (state_ff == S_DECIDE) begin
         if (hits_ff == 2'd1 && int'(rec_len) < MTL) begin
            len_ff[rec_slot]   <= rec_len + LW'(1);
            lastp_ff[rec_slot] <= p_ff;
            lx_ff[rec_slot]    <= px_ff;
            ly_ff[rec_slot]    <= py_ff;
         end else if (hits_ff == 2'd0 && seed_ok && int'(n_ff) < MC) begin
            len_ff[free_slot]   <= LW'(1);
            lastp_ff[free_slot] <= p_ff;
            lx_ff[free_slot]    <= px_ff;
            ly_ff[free_slot]    <= py_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         n_ff         <= '0;
         ovf_ff       <= 1'b0;
         k_ff         <= '0;
         hitv_ff      <= '0;
         hits_ff      <= 2'd0;
         first_ff     <= '0;
         erase_ff     <= 1'b0;
         acc_ff       <= '0;
         total_ff     <= '0;
         ek_ff        <= '0;
         cj_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MC; i++) begin
            ord_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  k_ff    <= '0;
                  hitv_ff <= '0;
                  hits_ff <= 2'd0;
                  acc_ff  <= '0;
                  case (req_operation)
                     OP_CLUSTER: begin
                        if (5'(req_plane) < np) begin
                           state_ff <= (n_ff == '0) ? S_DECIDE : S_CMP;
                        end
                     end
                     OP_PLANE_DONE: begin
                        if (n_ff != '0) begin
                           erase_ff <= 1'b0;
                           k_ff     <= n_ff - NW'(1);
                           state_ff <= S_SWEEP;
                        end
                     end
                     OP_EVENT_DONE: state_ff <= S_SUM;
                     default:       ;
                  endcase
               end
            end
            S_CMP: begin
               // issue one candidate per cycle, collect hits in order
               if (iss_valid) begin
                  k_ff <= k_ff + NW'(1);
               end
               if (mres.valid) begin
                  hitv_ff[mres_idx] <= mres.hit;
                  if (mres.hit) begin
                     if (hits_ff == 2'd0) begin
                        first_ff <= mres_idx;
                     end
                     if (hits_ff != 2'd2) begin
                        hits_ff <= hits_ff + 2'd1;
                     end
                  end
                  if (NW'(mres_idx) == n_ff - NW'(1)) begin
                     state_ff <= S_DECIDE;
                  end
               end
            end
            S_DECIDE: begin
               state_ff <= S_IDLE;
               if (hits_ff == 2'd1) begin
                  if (int'(rec_len) >= MTL) begin
                     ovf_ff <= 1'b1;
                  end
               end else if (hits_ff == 2'd2) begin
                  erase_ff <= 1'b1;
                  k_ff     <= n_ff - NW'(1);
                  state_ff <= S_SWEEP;
               end else if (seed_ok) begin
                  if (int'(n_ff) >= MC) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     used_ff[free_slot]     <= 1'b1;
                     ord_ff[n_ff[CIW-1:0]] <= free_slot;
                     n_ff                   <= n_ff + NW'(1);
                  end
               end
            end
            S_SWEEP: begin
               // walk down from the top so lower positions keep their index
               if (drop_now) begin
                  used_ff[rec_slot] <= 1'b0;
                  for (int i = 0; i < MC - 1; i++) begin
                     if (i >= int'(k_ff) && i + 1 < int'(n_ff)) begin
                        ord_ff[i] <= ord_ff[i + 1];
                     end
                  end
                  n_ff <= n_ff - NW'(1);
               end
               if (k_ff == '0) begin
                  state_ff <= S_IDLE;
               end else begin
                  k_ff <= k_ff - NW'(1);
               end
            end
            S_SUM: begin
               if (k_ff < n_ff) begin
                  acc_ff <= acc_ff + TW'(rec_len);
                  k_ff   <= k_ff + NW'(1);
               end else begin
                  k_ff  <= '0;
                  cj_ff <= '0;
                  ek_ff <= '0;
                  if (int'(acc_ff) > RESULT_CAP) begin
                     ovf_ff   <= 1'b1;
                     total_ff <= 7'(RESULT_CAP);
                  end else begin
                     total_ff <= 7'(acc_ff);
                  end
                  if (n_ff == '0) begin
                     // empty event: one marker result
                     rsp_valid_ff <= 1'b1;
                     rsp_entry_ff <= 1'b0;
                     rsp_track_ff <= 3'd0;
                     rsp_id_ff    <= 8'd0;
                     rsp_plane_ff <= 3'd0;
                     rsp_lot_ff   <= 1'b0;
                     rsp_loe_ff   <= 1'b1;
                     rsp_ovf_ff   <= ovf_ff;
                     state_ff     <= S_EOUT;
                  end else begin
                     state_ff <= S_ERD;
                  end
               end
            end
            S_ERD: state_ff <= S_EWT;
            S_EWT: begin
               rsp_valid_ff <= 1'b1;
               rsp_entry_ff <= 1'b1;
               rsp_track_ff <= 3'(k_ff);
               rsp_id_ff    <= mm_rd_data[7:0];
               rsp_plane_ff <= mm_rd_data[10:8];
               rsp_lot_ff   <= ((LW'(cj_ff) + LW'(1)) == rec_len)
                               || ((ek_ff + 7'd1) == total_ff);
               rsp_loe_ff   <= (ek_ff + 7'd1) == total_ff;
               rsp_ovf_ff   <= ovf_ff;
               state_ff     <= S_EOUT;
            end
            S_EOUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_loe_ff) begin
                     // event closed: drop all candidates and the flag
                     used_ff  <= '0;
                     n_ff     <= '0;
                     ovf_ff   <= 1'b0;
                     state_ff <= S_IDLE;
                  end else begin
                     ek_ff <= ek_ff + 7'd1;
                     if ((LW'(cj_ff) + LW'(1)) == rec_len) begin
                        k_ff  <= k_ff + NW'(1);
                        cj_ff <= '0;
                     end else begin
                        cj_ff <= cj_ff + JW'(1);
                     end
                     state_ff <= S_ERD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_valid    = rsp_entry_ff;
   assign rsp_track_index    = rsp_track_ff;
   assign rsp_out_cluster_id = rsp_id_ff;
   assign rsp_out_plane      = rsp_plane_ff;
   assign rsp_last_of_track  = rsp_lot_ff;
   assign rsp_last_of_event  = rsp_loe_ff;
   assign rsp_overflow       = rsp_ovf_ff;

endmodule

### design/tca_scale_mem.sv
// Inverse-RMS scale tables for x and y, indexed by plane pair.
// Unwritten entries read as zero through per-entry valid bits. Uses tca_pkg.
module tca_scale_mem #(
   parameter int MAX_PLANES = 8,
   parameter int AW         = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic          wr_y,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_x,
   output logic [15:0]   rd_y
);
   import tca_pkg::*;

   localparam int DEPTH = MAX_PLANES * MAX_PLANES;

   logic [15:0]      mem_x [DEPTH];
   logic [15:0]      mem_y [DEPTH];
   logic [DEPTH-1:0] vld_x_ff;
   logic [DEPTH-1:0] vld_y_ff;
   logic [15:0]      dat_x_ff;
   logic [15:0]      dat_y_ff;
   logic             hit_x_ff;
   logic             hit_y_ff;

   always_ff @(posedge clock) begin
      if (wr_en && !wr_y) begin
         mem_x[wr_addr] <= wr_data;
      end
      if (wr_en && wr_y) begin
         mem_y[wr_addr] <= wr_data;
      end
      dat_x_ff <= mem_x[rd_addr];
      dat_y_ff <= mem_y[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_x_ff <= '0;
         vld_y_ff <= '0;
         hit_x_ff <= 1'b0;
         hit_y_ff <= 1'b0;
      end else begin
         if (wr_en && !wr_y) begin
            vld_x_ff[wr_addr] <= 1'b1;
         end
         if (wr_en && wr_y) begin
            vld_y_ff[wr_addr] <= 1'b1;
         end
         hit_x_ff <= vld_x_ff[rd_addr];
         hit_y_ff <= vld_y_ff[rd_addr];
      end
   end

   assign rd_x = hit_x_ff ? dat_x_ff : 16'd0;
   assign rd_y = hit_y_ff ? dat_y_ff : 16'd0;

endmodule

### design/tca_member_mem.sv
// Candidate member list store: one read port, one write port, registered read.
// Uses tca_pkg for the entry width.
module tca_member_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [tca_pkg::MEMBER_W-1:0] wr_data,
   input  logic [AW-1:0]                rd_addr,
   output logic [tca_pkg::MEMBER_W-1:0] rd_data
);
   import tca_pkg::*;

   logic [MEMBER_W-1:0] mem [DEPTH];
   logic [MEMBER_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tca_match.sv
// Four-stage distance pipeline: scale each step, square, sum and compare.
// Scale data arrives in the cycle after the issue. Uses tca_pkg.
module tca_match #(
   parameter int CIW = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         iss_valid,
   input  logic [CIW-1:0]               iss_idx,
   input  logic [15:0]                  iss_ax,
   input  logic [15:0]                  iss_ay,
   input  logic [15:0]                  scale_x,
   input  logic [15:0]                  scale_y,
   input  logic [tca_pkg::RADIUS_W-1:0] radius_sq,
   output tca_pkg::match_flag_type      res,
   output logic [CIW-1:0]               res_idx
);
   import tca_pkg::*;

   logic           v1_ff, v2_ff, v3_ff;
   logic [CIW-1:0] idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [15:0]    ax1_ff, ay1_ff;
   logic [31:0]    mx2_ff, my2_ff;
   logic [63:0]    sx3_ff, sy3_ff;
   logic [64:0]    sum;
   match_flag_type res_ff;

   assign sum = {1'b0, sx3_ff} + {1'b0, sy3_ff};

   always_ff @(posedge clock) begin
      idx1_ff <= iss_idx;
      ax1_ff  <= iss_ax;
      ay1_ff  <= iss_ay;
      idx2_ff <= idx1_ff;
      mx2_ff  <= 32'(ax1_ff) * 32'(scale_x);
      my2_ff  <= 32'(ay1_ff) * 32'(scale_y);
      idx3_ff <= idx2_ff;
      sx3_ff  <= 64'(mx2_ff) * 64'(mx2_ff);
      sy3_ff  <= 64'(my2_ff) * 64'(my2_ff);
      idx4_ff <= idx3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         res_ff <= '0;
      end else begin
         v1_ff        <= iss_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         res_ff.valid <= v3_ff;
         // sums that carry out of 64 bits never match
         res_ff.hit   <= !sum[64] && (sum[63:0] <= 64'(radius_sq));
      end
   end

   assign res     = res_ff;
   assign res_idx = idx4_ff;

endmodule

### design/tca_checker.sv
// Port-level checks for the tracklet cluster association block, bound to the
// top level. Depends on the top level's port names only.
module tca_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_entry_valid,
   input logic [2:0]                   rsp_track_index,
   input logic [7:0]                   rsp_out_cluster_id,
   input logic [2:0]                   rsp_out_plane,
   input logic                         rsp_last_of_track,
   input logic                         rsp_last_of_event,
   input logic                         rsp_overflow
);

   // under a receiver stall the result stays valid and its cluster id, last-of-event and overflow hold
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_cluster_id)
                                 && $stable(rsp_last_of_event) && $stable(rsp_overflow))
      else $error("result changed under stall");

   // no new item is taken while results of an event are going out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken during event output");

   // an empty-event marker closes the event and carries no track
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_last_of_event && !rsp_last_of_track
                                        && rsp_out_cluster_id == 8'd0
                                        && rsp_track_index == 3'd0
                                        && rsp_out_plane == 3'd0)
      else $error("malformed empty-event result");

   // the final cluster of an event also ends its track
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_valid && rsp_last_of_event |-> rsp_last_of_track)
      else $error("event ended inside a track");

endmodule

bind tracklet_cluster_association tca_checker u_tca_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_entry_valid    (rsp_entry_valid),
   .rsp_track_index    (rsp_track_index),
   .rsp_out_cluster_id (rsp_out_cluster_id),
   .rsp_out_plane      (rsp_out_plane),
   .rsp_last_of_track  (rsp_last_of_track),
   .rsp_last_of_event  (rsp_last_of_event),
   .rsp_overflow       (rsp_overflow)
);
